// ----- hdl/sncp_pkg.sv -----
// Shared types, constants and fixed-point helpers for the near-plane clip
// and projection pipeline. No dependencies.
package sncp_pkg;

  localparam int CW = 32;
  localparam int FB = 16;

  typedef logic signed [CW-1:0] q_t;
  typedef logic [15:0][CW-1:0] mat_t;

  localparam q_t ONE_Q = q_t'(64'(1) << FB);
  localparam q_t MAX_Q = {1'b0, {(CW-1){1'b1}}};
  localparam q_t MIN_Q = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW:0] DEPTH_EPS = (CW+1)'((64'(1) << FB) / 1000000);
  localparam q_t W_EPS = q_t'((64'(1) << FB) / 100000);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SEG  = 1'b1;
  localparam logic SEL_VIEW  = 1'b0;
  localparam logic SEL_PROJ  = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_NEAR   = 2'd2;

  localparam logic [14:0] WIDTH_RST  = 15'd1920;
  localparam logic [14:0] HEIGHT_RST = 15'd1080;
  localparam logic [30:0] NEAR_RST   = 31'd1966;

  typedef struct packed {
    logic              kind;
    logic              matrix_select;
    logic [3:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } req_t;

  typedef struct packed {
    logic              visible;
    logic signed [31:0] screen_x0;
    logic signed [31:0] screen_y0;
    logic signed [31:0] screen_x1;
    logic signed [31:0] screen_y1;
  } rsp_t;

  // carried alongside the t divider
  typedef struct packed {
    logic [2:0][CW-1:0] p0;
    logic [2:0][CW-1:0] p1;
    logic               vis;
    logic               in0;
    logic               clip;
    logic               tz;
    logic               tone;
  } clip_pl_t;

  // carried alongside each viewport divider
  typedef struct packed {
    logic vis;
    logic neg;
    logic ovf;
  } prj_pl_t;

  function automatic logic signed [CW:0] ext(input q_t v);
    return {v[CW-1], v};
  endfunction

  function automatic logic signed [CW+3:0] wide(input q_t v);
    return (CW+4)'(v);
  endfunction

  function automatic logic [CW:0] mag(input logic signed [CW:0] v);
    return v[CW] ? (CW+1)'(-v) : (CW+1)'(v);
  endfunction

  function automatic logic [63:0] mul_mag(input logic signed [CW:0] a,
                                          input logic signed [CW:0] b);
    return 64'(mag(a)) * 64'(mag(b));
  endfunction

  function automatic logic mul_neg(input logic signed [CW:0] a,
                                   input logic signed [CW:0] b);
    return a[CW] ^ b[CW];
  endfunction

  function automatic q_t sat_cw(input logic signed [CW+3:0] v);
    if (v > wide(MAX_Q)) return MAX_Q;
    if (v < wide(MIN_Q)) return MIN_Q;
    return v[CW-1:0];
  endfunction

  // product magnitude >> FB, truncated, signed and saturated
  function automatic q_t mulq_fin(input logic [63:0] pm, input logic neg);
    logic [63-FB:0] s;
    s = pm[63:FB];
    if (|s[63-FB:CW-1]) return neg ? MIN_Q : MAX_Q;
    return neg ? q_t'(-s[CW-1:0]) : q_t'(s[CW-1:0]);
  endfunction

endpackage

// ----- hdl/sncp_mat.sv -----
// View and projection matrix store, loaded one entry per request.
// Depends on sncp_pkg.
module sncp_mat (
  input  logic           clk,
  input  logic           rst,
  input  logic           we,
  input  logic           sel,
  input  logic [3:0]     idx,
  input  sncp_pkg::q_t   val,
  output sncp_pkg::mat_t view,
  output sncp_pkg::mat_t proj
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        view[k] <= (k % 5 == 0) ? sncp_pkg::ONE_Q : '0;
        proj[k] <= (k % 5 == 0) ? sncp_pkg::ONE_Q : '0;
      end
    end else if (we) begin
      if (sel == sncp_pkg::SEL_PROJ) proj[idx] <= val;
      else view[idx] <= val;
    end
  end

endmodule

// ----- hdl/sncp_div.sv -----
// Pipelined restoring divider, SPS quotient bits per stage, with payload.
// Remainder input must be below the divisor. Depends on nothing.
module sncp_div #(
  parameter int DW  = 33,
  parameter int QB  = 16,
  parameter int SPS = 2,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_in,
  input  logic [QB-1:0] feed,
  input  logic [DW-1:0] dvs,
  input  logic [PW-1:0] pl,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic [PW-1:0] pl_out
);

  localparam int NS = (QB + SPS - 1) / SPS;

  logic          vld [1:NS];
  logic [DW-1:0] rem [1:NS];
  logic [QB-1:0] fd  [1:NS];
  logic [QB-1:0] q   [1:NS];
  logic [DW-1:0] d   [1:NS];
  logic [PW-1:0] pay [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int NST = (QB - s * SPS < SPS) ? (QB - s * SPS) : SPS;
    logic          src_v;
    logic [DW-1:0] src_r, src_d;
    logic [QB-1:0] src_f, src_q;
    logic [PW-1:0] src_p;
    logic [DW-1:0] r_n;
    logic [QB-1:0] f_n, q_n;

    if (s == 0) begin : g_src
      assign src_v = in_valid;
      assign src_r = rem_in;
      assign src_f = feed;
      assign src_q = '0;
      assign src_d = dvs;
      assign src_p = pl;
    end else begin : g_src
      assign src_v = vld[s];
      assign src_r = rem[s];
      assign src_f = fd[s];
      assign src_q = q[s];
      assign src_d = d[s];
      assign src_p = pay[s];
    end

    always_comb begin
      logic [DW:0] rw;
      rw  = '0;
      r_n = src_r;
      f_n = src_f;
      q_n = src_q;
      for (int k = 0; k < NST; k++) begin
        rw  = {r_n, f_n[QB-1]};
        f_n = f_n << 1;
        if (rw >= {1'b0, src_d}) begin
          rw  = rw - {1'b0, src_d};
          q_n = {q_n[QB-2:0], 1'b1};
        end else begin
          q_n = {q_n[QB-2:0], 1'b0};
        end
        r_n = rw[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= r_n;
        fd[s+1]  <= f_n;
        q[s+1]   <= q_n;
        d[s+1]   <= src_d;
        pay[s+1] <= src_p;
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo       = q[NS];
  assign pl_out    = pay[NS];

endmodule

// ----- hdl/segment_near_clip_and_project.sv -----
// Near-plane segment clip and viewport projection, Q16.16, fully pipelined.
// 37 register stages from request to result, mostly in the 16-stage viewport
// divider and the 8-stage clip-ratio divider.
// Throughput one segment per cycle; all stages freeze together while the result is held.
// A matrix load or register write waits until no segment is in flight; loads give no result.
// Reset (rst, synchronous): pipeline empty, matrices identity, screen 1920x1080,
// near depth 1966.
module segment_near_clip_and_project (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sncp_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sncp_pkg::rsp_t    rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int CW    = sncp_pkg::CW;
  localparam int FB    = sncp_pkg::FB;
  localparam int SPS   = 2;
  localparam int QB2   = CW - 1;
  localparam int NW    = CW + 1 + 15;
  localparam int NSW   = NW + FB - 1;
  localparam int NS1   = (FB + SPS - 1) / SPS;
  localparam int NS2   = (QB2 + SPS - 1) / SPS;
  localparam int LAT   = 4 + NS1 + 8 + NS2 + 1;
  localparam int CNT_W = $clog2(LAT + 1);

  // ---------------- request handshake ----------------
  logic             adv, acc, acc_seg, acc_load, rsp_take;
  logic [CNT_W-1:0] inflight;

  // ---------------- configuration ----------------
  logic [14:0] screen_width, screen_height;
  logic [30:0] near_depth;

  // registers are read mid-pipeline, so only change them when it is empty
  assign cfg_ready = (inflight == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= sncp_pkg::WIDTH_RST;
      screen_height <= sncp_pkg::HEIGHT_RST;
      near_depth    <= sncp_pkg::NEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sncp_pkg::REG_WIDTH:  screen_width  <= cfg_data[14:0];
        sncp_pkg::REG_HEIGHT: screen_height <= cfg_data[14:0];
        sncp_pkg::REG_NEAR:   near_depth    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign adv      = !rsp_valid || rsp_ready;
  assign req_ready = adv && (req.kind == sncp_pkg::KIND_SEG || inflight == '0);
  assign acc      = req_valid && req_ready;
  assign acc_seg  = acc && req.kind == sncp_pkg::KIND_SEG;
  assign acc_load = acc && req.kind == sncp_pkg::KIND_LOAD;
  assign rsp_take = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + CNT_W'(acc_seg) - CNT_W'(rsp_take);
  end

  sncp_pkg::mat_t vm, pm;

  sncp_mat u_mat (
    .clk  (clk),
    .rst  (rst),
    .we   (acc_load),
    .sel  (req.matrix_select),
    .idx  (req.entry_index),
    .val  (req.entry_value),
    .view (vm),
    .proj (pm)
  );

  // ---------------- stage 1: input ----------------
  logic         s1_v;
  sncp_pkg::q_t s1_p [2][3];

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= acc_seg;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p[0][0] <= req.start_x; s1_p[0][1] <= req.start_y; s1_p[0][2] <= req.start_z;
      s1_p[1][0] <= req.end_x;   s1_p[1][1] <= req.end_y;   s1_p[1][2] <= req.end_z;
    end
  end

  // ---------------- stage 2: view-depth products ----------------
  logic         s2_v;
  sncp_pkg::q_t s2_p [2][3];
  logic [63:0]  s2_pm [2][3];
  logic         s2_ng [2][3];

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 3; i++) begin
          s2_p[j][i]  <= s1_p[j][i];
          s2_pm[j][i] <= sncp_pkg::mul_mag(sncp_pkg::ext(vm[8+i]),
                                           sncp_pkg::ext(s1_p[j][i]));
          s2_ng[j][i] <= sncp_pkg::mul_neg(sncp_pkg::ext(vm[8+i]),
                                           sncp_pkg::ext(s1_p[j][i]));
        end
      end
    end
  end

  // ---------------- stage 3: view depth ----------------
  logic         s3_v;
  sncp_pkg::q_t s3_p [2][3];
  sncp_pkg::q_t s3_z [2];

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_p <= s2_p;
      for (int j = 0; j < 2; j++) begin
        s3_z[j] <= sncp_pkg::sat_cw(
          sncp_pkg::wide(sncp_pkg::mulq_fin(s2_pm[j][0], s2_ng[j][0])) +
          sncp_pkg::wide(sncp_pkg::mulq_fin(s2_pm[j][1], s2_ng[j][1])) +
          sncp_pkg::wide(sncp_pkg::mulq_fin(s2_pm[j][2], s2_ng[j][2])) +
          sncp_pkg::wide(vm[11]));
      end
    end
  end

  // ---------------- stage 4: near-plane test ----------------
  logic                 s4_v;
  sncp_pkg::clip_pl_t   s4_pl, cl_n;
  logic [CW:0]          s4_un, s4_ud, un_n, ud_n;

  always_comb begin
    logic signed [CW:0] near_s, num0, num1, den;
    logic               in1;
    near_s = $signed({2'b00, near_depth});
    num0   = sncp_pkg::ext(s3_z[0]) + near_s;
    num1   = sncp_pkg::ext(s3_z[1]) + near_s;
    den    = sncp_pkg::ext(s3_z[0]) - sncp_pkg::ext(s3_z[1]);
    in1    = num1 <= 0;
    for (int i = 0; i < 3; i++) begin
      cl_n.p0[i] = s3_p[0][i];
      cl_n.p1[i] = s3_p[1][i];
    end
    un_n      = sncp_pkg::mag(num0);
    ud_n      = sncp_pkg::mag(den);
    cl_n.in0  = num0 <= 0;
    cl_n.vis  = cl_n.in0 || in1;
    cl_n.clip = (cl_n.in0 != in1) && (ud_n > sncp_pkg::DEPTH_EPS);
    cl_n.tz   = (num0[CW] != den[CW]) && (num0 != '0);
    cl_n.tone = un_n >= ud_n;
  end

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pl <= cl_n;
      s4_un <= cl_n.tone ? '0 : un_n;
      s4_ud <= ud_n;
    end
  end

  // ---------------- clip ratio divider ----------------
  logic                           d1_v;
  logic [FB-1:0]                  d1_q;
  logic [$bits(sncp_pkg::clip_pl_t)-1:0] d1_raw;
  sncp_pkg::clip_pl_t             d1_pl;

  sncp_div #(.DW(CW + 1), .QB(FB), .SPS(SPS), .PW($bits(sncp_pkg::clip_pl_t))) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s4_v),
    .rem_in    (s4_un),
    .feed      ('0),
    .dvs       (s4_ud),
    .pl        (s4_pl),
    .out_valid (d1_v),
    .quo       (d1_q),
    .pl_out    (d1_raw)
  );

  assign d1_pl = sncp_pkg::clip_pl_t'(d1_raw);

  // ---------------- stage L1: interpolation products ----------------
  logic               s5_v;
  sncp_pkg::clip_pl_t s5_pl;
  logic [63:0]        s5_pm [3];
  logic               s5_ng [3];
  logic signed [CW:0] t_n;

  assign t_n = d1_pl.tz   ? '0 :
               d1_pl.tone ? sncp_pkg::ext(sncp_pkg::ONE_Q) :
                            $signed((CW+1)'(d1_q));

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (adv) s5_v <= d1_v;
  end

  always_ff @(posedge clk) begin
    logic signed [CW:0] df;
    if (adv) begin
      s5_pl <= d1_pl;
      for (int i = 0; i < 3; i++) begin
        df = sncp_pkg::ext(d1_pl.p1[i]) - sncp_pkg::ext(d1_pl.p0[i]);
        s5_pm[i] <= sncp_pkg::mul_mag(df, t_n);
        s5_ng[i] <= sncp_pkg::mul_neg(df, t_n);
      end
    end
  end

  // ---------------- stage L2: moved endpoint ----------------
  logic         s6_v, s6_vis;
  sncp_pkg::q_t s6_p [2][3];

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (adv) s6_v <= s5_v;
  end

  always_ff @(posedge clk) begin
    sncp_pkg::q_t m;
    if (adv) begin
      s6_vis <= s5_pl.vis;
      for (int i = 0; i < 3; i++) begin
        m = sncp_pkg::sat_cw(sncp_pkg::wide(s5_pl.p0[i]) +
                             sncp_pkg::wide(sncp_pkg::mulq_fin(s5_pm[i], s5_ng[i])));
        s6_p[0][i] <= (s5_pl.clip && !s5_pl.in0) ? m : s5_pl.p0[i];
        s6_p[1][i] <= (s5_pl.clip &&  s5_pl.in0) ? m : s5_pl.p1[i];
      end
    end
  end

  // ---------------- stage V1/V2: view transform ----------------
  logic         s7_v, s7_vis;
  logic [63:0]  s7_pm [2][4][3];
  logic         s7_ng [2][4][3];

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (adv) s7_v <= s6_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_vis <= s6_vis;
      for (int j = 0; j < 2; j++)
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 3; c++) begin
            s7_pm[j][r][c] <= sncp_pkg::mul_mag(sncp_pkg::ext(vm[r*4+c]),
                                                sncp_pkg::ext(s6_p[j][c]));
            s7_ng[j][r][c] <= sncp_pkg::mul_neg(sncp_pkg::ext(vm[r*4+c]),
                                                sncp_pkg::ext(s6_p[j][c]));
          end
    end
  end

  logic         s8_v, s8_vis;
  sncp_pkg::q_t s8_e [2][4];

  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (adv) s8_v <= s7_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_vis <= s7_vis;
      for (int j = 0; j < 2; j++)
        for (int r = 0; r < 4; r++)
          s8_e[j][r] <= sncp_pkg::sat_cw(
            sncp_pkg::wide(sncp_pkg::mulq_fin(s7_pm[j][r][0], s7_ng[j][r][0])) +
            sncp_pkg::wide(sncp_pkg::mulq_fin(s7_pm[j][r][1], s7_ng[j][r][1])) +
            sncp_pkg::wide(sncp_pkg::mulq_fin(s7_pm[j][r][2], s7_ng[j][r][2])) +
            sncp_pkg::wide(vm[r*4+3]));
    end
  end

  // ---------------- stage P1/P2: projection ----------------
  logic         s9_v, s9_vis;
  logic [63:0]  s9_pm [2][4][4];
  logic         s9_ng [2][4][4];

  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (adv) s9_v <= s8_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_vis <= s8_vis;
      for (int j = 0; j < 2; j++)
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) begin
            s9_pm[j][r][c] <= sncp_pkg::mul_mag(sncp_pkg::ext(pm[r*4+c]),
                                                sncp_pkg::ext(s8_e[j][c]));
            s9_ng[j][r][c] <= sncp_pkg::mul_neg(sncp_pkg::ext(pm[r*4+c]),
                                                sncp_pkg::ext(s8_e[j][c]));
          end
    end
  end

  logic         s10_v, s10_vis;
  sncp_pkg::q_t s10_c [2][4];

  always_ff @(posedge clk) begin
    if (rst) s10_v <= 1'b0;
    else if (adv) s10_v <= s9_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_vis <= s9_vis;
      for (int j = 0; j < 2; j++)
        for (int r = 0; r < 4; r++)
          s10_c[j][r] <= sncp_pkg::sat_cw(
            sncp_pkg::wide(sncp_pkg::mulq_fin(s9_pm[j][r][0], s9_ng[j][r][0])) +
            sncp_pkg::wide(sncp_pkg::mulq_fin(s9_pm[j][r][1], s9_ng[j][r][1])) +
            sncp_pkg::wide(sncp_pkg::mulq_fin(s9_pm[j][r][2], s9_ng[j][r][2])) +
            sncp_pkg::wide(sncp_pkg::mulq_fin(s9_pm[j][r][3], s9_ng[j][r][3])));
    end
  end

  // ---------------- stage Q1: viewport scale ----------------
  // lanes: x0, y0 (divide by w0), x1, y1 (divide by w1)
  logic         s11_v, s11_vis;
  logic [NW-1:0] s11_n [4];
  logic         s11_ng [4];
  sncp_pkg::q_t s11_w [2];

  always_ff @(posedge clk) begin
    if (rst) s11_v <= 1'b0;
    else if (adv) s11_v <= s10_v;
  end

  always_ff @(posedge clk) begin
    logic signed [CW:0] ax, ay;
    if (adv) begin
      s11_vis <= s10_vis && (s10_c[0][3] > sncp_pkg::W_EPS) &&
                 (s10_c[1][3] > sncp_pkg::W_EPS);
      for (int j = 0; j < 2; j++) begin
        ax = sncp_pkg::ext(s10_c[j][0]) + sncp_pkg::ext(s10_c[j][3]);
        ay = sncp_pkg::ext(s10_c[j][3]) - sncp_pkg::ext(s10_c[j][1]);
        s11_n[2*j]    <= NW'(sncp_pkg::mag(ax)) * NW'(screen_width);
        s11_n[2*j+1]  <= NW'(sncp_pkg::mag(ay)) * NW'(screen_height);
        s11_ng[2*j]   <= ax[CW];
        s11_ng[2*j+1] <= ay[CW];
        s11_w[j]      <= s10_c[j][3];
      end
    end
  end

  // ---------------- stage Q2: divider setup ----------------
  logic              s12_v;
  logic [CW-1:0]     s12_rem [4];
  logic [QB2-1:0]    s12_fd  [4];
  logic [CW-1:0]     s12_w   [2];
  sncp_pkg::prj_pl_t s12_pl  [4];

  always_ff @(posedge clk) begin
    if (rst) s12_v <= 1'b0;
    else if (adv) s12_v <= s11_v;
  end

  always_ff @(posedge clk) begin
    logic [NSW-1:0] nsh;
    logic [CW-1:0]  top;
    logic           ovf;
    if (adv) begin
      for (int j = 0; j < 2; j++) s12_w[j] <= s11_w[j];
      for (int k = 0; k < 4; k++) begin
        nsh = {s11_n[k], {(FB-1){1'b0}}};
        top = nsh[NSW-1 -: CW];
        // quotient would not fit: saturate instead of dividing
        ovf = top >= s11_w[k/2];
        s12_rem[k]    <= ovf ? '0 : top;
        s12_fd[k]     <= nsh[QB2-1:0];
        s12_pl[k].vis <= s11_vis;
        s12_pl[k].neg <= s11_ng[k];
        s12_pl[k].ovf <= ovf;
      end
    end
  end

  // ---------------- viewport dividers ----------------
  logic              d2_v;
  logic [QB2-1:0]    d2_q  [4];
  logic [$bits(sncp_pkg::prj_pl_t)-1:0] d2_raw [4];

  for (genvar k = 0; k < 4; k++) begin : g_vdiv
    if (k == 0) begin : g_lead
      sncp_div #(.DW(CW), .QB(QB2), .SPS(SPS), .PW($bits(sncp_pkg::prj_pl_t))) u_vdiv (
        .clk (clk), .rst (rst), .adv (adv), .in_valid (s12_v),
        .rem_in (s12_rem[k]), .feed (s12_fd[k]), .dvs (s12_w[k/2]), .pl (s12_pl[k]),
        .out_valid (d2_v), .quo (d2_q[k]), .pl_out (d2_raw[k])
      );
    end else begin : g_lane
      sncp_div #(.DW(CW), .QB(QB2), .SPS(SPS), .PW($bits(sncp_pkg::prj_pl_t))) u_vdiv (
        .clk (clk), .rst (rst), .adv (adv), .in_valid (s12_v),
        .rem_in (s12_rem[k]), .feed (s12_fd[k]), .dvs (s12_w[k/2]), .pl (s12_pl[k]),
        .out_valid (), .quo (d2_q[k]), .pl_out (d2_raw[k])
      );
    end
  end

  // ---------------- output register ----------------
  sncp_pkg::q_t      scr [4];
  sncp_pkg::prj_pl_t lpl [4];
  logic              vis_o;

  always_comb begin
    vis_o = 1'b1;
    for (int k = 0; k < 4; k++) begin
      lpl[k] = sncp_pkg::prj_pl_t'(d2_raw[k]);
      vis_o  = vis_o && lpl[k].vis;
      if (lpl[k].ovf)
        scr[k] = lpl[k].neg ? sncp_pkg::MIN_Q : sncp_pkg::MAX_Q;
      else
        scr[k] = lpl[k].neg ? sncp_pkg::q_t'(-{1'b0, d2_q[k]}) :
                              sncp_pkg::q_t'({1'b0, d2_q[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (adv) rsp_valid <= d2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.visible   <= vis_o;
      rsp.screen_x0 <= vis_o ? scr[0] : '0;
      rsp.screen_y0 <= vis_o ? scr[1] : '0;
      rsp.screen_x1 <= vis_o ? scr[2] : '0;
      rsp.screen_y1 <= vis_o ? scr[3] : '0;
    end
  end

endmodule
